// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/cst_pkg.sv -----
// Shared types and constants of the character stream tokenizer.
package cst_pkg;

   localparam int OFFSET_BITS   = 24;
   localparam int POSITION_BITS = 16;
   localparam int LENGTH_BITS   = 16;
   localparam int PREFIX_CHARS  = 5;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_AT         = 8'h40;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0a;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

   localparam logic [8*PREFIX_CHARS-1:0] WORD_VOID  = {8'h00, "d", "i", "o", "v"};
   localparam logic [8*PREFIX_CHARS-1:0] WORD_INT   = {16'h0000, "t", "n", "i"};
   localparam logic [8*PREFIX_CHARS-1:0] WORD_ABORT = {"t", "r", "o", "b", "a"};

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_HALTED = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      KIND_IDENT   = 4'd0,
      KIND_VOID    = 4'd1,
      KIND_INT     = 4'd2,
      KIND_ABORT   = 4'd3,
      KIND_LITERAL = 4'd4,
      KIND_LPAREN  = 4'd5,
      KIND_RPAREN  = 4'd6,
      KIND_LBRACE  = 4'd7,
      KIND_RBRACE  = 4'd8,
      KIND_ASSIGN  = 4'd9,
      KIND_PLUS    = 4'd10,
      KIND_MINUS   = 4'd11,
      KIND_SEMI    = 4'd12,
      KIND_ERROR   = 4'd13
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [OFFSET_BITS-1:0]   offset;
      logic [POSITION_BITS-1:0] row;
      logic [POSITION_BITS-1:0] column;
      logic [LENGTH_BITS-1:0]   length;
      logic                     last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } scan_out_type;

endpackage

// ----- hdl/cst_scan.sv -----
// Scanner state and per-byte tokenizing logic; yields up to two tokens per byte.
module cst_scan import cst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   char_code,
   input  logic         end_of_text,
   output scan_out_type scan_out
);

   mode_type                    mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]      byte_ff, byte_in;
   logic [POSITION_BITS-1:0]    row_ff, row_in;
   logic [POSITION_BITS-1:0]    col_ff, col_in;
   logic [OFFSET_BITS-1:0]      pend_off_ff, pend_off_in;
   logic [POSITION_BITS-1:0]    pend_row_ff, pend_row_in;
   logic [POSITION_BITS-1:0]    pend_col_ff, pend_col_in;
   logic [LENGTH_BITS-1:0]      pend_len_ff, pend_len_in;
   logic [8*PREFIX_CHARS-1:0]   prefix_ff, prefix_in;

   logic      is_cont;
   logic      flush_old;
   logic      single_vld;
   logic      eot_flush;
   logic      err;
   kind_type  single_kind;
   token_type old_tok, single_tok, eot_tok, second_tok;
   logic      second_vld;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0d]};
   endfunction

   function automatic logic punct_hit(input logic [7:0] c);
      return c inside {"(", ")", "{", "}", "=", "+", "-", ";"};
   endfunction

   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "=":     k = KIND_ASSIGN;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         ";":     k = KIND_SEMI;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic kind_type pend_kind(input mode_type m, input logic [LENGTH_BITS-1:0] len,
                                          input logic [8*PREFIX_CHARS-1:0] pre);
      kind_type k;
      k = KIND_LITERAL;
      if (m == MODE_WORD) begin
         k = KIND_IDENT;
         if (len == LENGTH_BITS'(4) && pre == WORD_VOID) begin
            k = KIND_VOID;
         end else if (len == LENGTH_BITS'(3) && pre == WORD_INT) begin
            k = KIND_INT;
         end else if (len == LENGTH_BITS'(5) && pre == WORD_ABORT) begin
            k = KIND_ABORT;
         end
      end
      return k;
   endfunction

   assign is_cont = (mode_ff == MODE_WORD &&
                     (is_letter(char_code) || is_digit(char_code) ||
                      char_code == CHAR_UNDERSCORE)) ||
                    (mode_ff == MODE_NUMBER && is_digit(char_code));

   always_comb begin
      mode_in     = mode_ff;
      byte_in     = byte_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pend_off_in = pend_off_ff;
      pend_row_in = pend_row_ff;
      pend_col_in = pend_col_ff;
      pend_len_in = pend_len_ff;
      prefix_in   = prefix_ff;
      flush_old   = 1'b0;
      single_vld  = 1'b0;
      single_kind = KIND_ERROR;
      eot_flush   = 1'b0;
      err         = 1'b0;
      eot_tok     = '0;
      if (fire && mode_ff != MODE_HALTED) begin
         if (is_cont) begin
            for (int i = 0; i < PREFIX_CHARS; i++) begin
               if (pend_len_ff == LENGTH_BITS'(i)) begin
                  prefix_in[8*i +: 8] = char_code;
               end
            end
            pend_len_in = (pend_len_ff == '1) ? pend_len_ff : pend_len_ff + 1'b1;
         end else begin
            flush_old = (mode_ff == MODE_WORD) || (mode_ff == MODE_NUMBER);
            mode_in   = MODE_IDLE;
            if (is_letter(char_code) || is_digit(char_code) ||
                char_code == CHAR_UNDERSCORE || char_code == CHAR_AT) begin
               mode_in     = is_digit(char_code) ? MODE_NUMBER : MODE_WORD;
               pend_off_in = byte_ff;
               pend_row_in = row_ff;
               pend_col_in = col_ff;
               pend_len_in = LENGTH_BITS'(1);
               prefix_in   = {{(8*PREFIX_CHARS-8){1'b0}}, char_code};
            end else if (punct_hit(char_code)) begin
               single_vld  = 1'b1;
               single_kind = punct_kind(char_code);
            end else if (!is_space(char_code)) begin
               single_vld  = 1'b1;
               single_kind = KIND_ERROR;
               err         = 1'b1;
               mode_in     = MODE_HALTED;
            end
         end
         if (!err) begin
            byte_in = (byte_ff == '1) ? byte_ff : byte_ff + 1'b1;
            if (char_code == CHAR_NEWLINE) begin
               row_in = (row_ff == '1) ? row_ff : row_ff + 1'b1;
               col_in = POSITION_BITS'(1);
            end else begin
               col_in = (col_ff == '1) ? col_ff : col_ff + 1'b1;
            end
            if (end_of_text) begin
               eot_flush      = (mode_in == MODE_WORD) || (mode_in == MODE_NUMBER);
               eot_tok.kind   = pend_kind(mode_in, pend_len_in, prefix_in);
               eot_tok.offset = pend_off_in;
               eot_tok.row    = pend_row_in;
               eot_tok.column = pend_col_in;
               eot_tok.length = pend_len_in;
               eot_tok.last   = 1'b1;
               mode_in        = MODE_IDLE;
               byte_in        = '0;
               row_in         = POSITION_BITS'(1);
               col_in         = POSITION_BITS'(1);
               pend_len_in    = '0;
               prefix_in      = '0;
            end
         end
      end
   end

   always_comb begin
      old_tok.kind   = pend_kind(mode_ff, pend_len_ff, prefix_ff);
      old_tok.offset = pend_off_ff;
      old_tok.row    = pend_row_ff;
      old_tok.column = pend_col_ff;
      old_tok.length = pend_len_ff;
      old_tok.last   = 1'b1;

      single_tok.kind   = single_kind;
      single_tok.offset = byte_ff;
      single_tok.row    = row_ff;
      single_tok.column = col_ff;
      single_tok.length = LENGTH_BITS'(1);
      single_tok.last   = 1'b1;

      second_vld = single_vld || eot_flush;
      second_tok = single_vld ? single_tok : eot_tok;

      scan_out.count = {1'b0, flush_old} + {1'b0, second_vld};
      scan_out.tok0  = flush_old ? old_tok : second_tok;
      scan_out.tok0.last = !(flush_old && second_vld);
      scan_out.tok1  = second_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         byte_ff     <= '0;
         row_ff      <= POSITION_BITS'(1);
         col_ff      <= POSITION_BITS'(1);
         pend_off_ff <= '0;
         pend_row_ff <= POSITION_BITS'(1);
         pend_col_ff <= POSITION_BITS'(1);
         pend_len_ff <= '0;
         prefix_ff   <= '0;
      end else begin
         mode_ff     <= mode_in;
         byte_ff     <= byte_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         pend_off_ff <= pend_off_in;
         pend_row_ff <= pend_row_in;
         pend_col_ff <= pend_col_in;
         pend_len_ff <= pend_len_in;
         prefix_ff   <= prefix_in;
      end
   end

endmodule

// ----- hdl/char_stream_tokenizer_unit.sv -----
// Top level of the character stream tokenizer: input register, scanner, token queue.
//
// Source text enters on the req_ stream, one byte per beat; req_tlast marks the
// last byte of a text and flushes any pending word or number. Tokens leave on the
// rsp_ stream, one per beat; rsp_tlast marks the last token caused by one byte.
// One byte yields zero, one or two tokens.
// An accepted byte passes through the input register and the token queue before its tokens appear on rsp_.
// Throughput: one byte per cycle; the scanner fires on the registered byte when
// the four-entry token queue has room for two tokens, so the output side drains
// one token per cycle and a run of two-token bytes limits the input to that rate.
// When the receiver stalls, the queue fills and req_tready drops; nothing is lost.
// An illegal byte gives an error token and halts the scanner: later bytes are
// taken and dropped without tokens until reset.
// Reset (synchronous, active high) empties the queue and the input register and
// returns the scanner to offset 0, row 1, column 1.
module char_stream_tokenizer_unit import cst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [3:0] token_kind, [27:4] start_offset,
                                    // [43:28] start_row, [59:44] start_column,
                                    // [75:60] token_length, [79:76] zero
   output logic        rsp_tlast    // last_in_run
);

   logic         in_vld_ff, in_vld_in;
   logic [7:0]   in_char_ff;
   logic         in_eot_ff;
   logic         fire;
   logic         pop;
   scan_out_type scan_out;

   token_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   token_type                 head;

   assign fire       = in_vld_ff && (count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
   assign req_tready = !in_vld_ff || fire;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   cst_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .char_code   (in_char_ff),
      .end_of_text (in_eot_ff),
      .scan_out    (scan_out)
   );

   assign pop       = rsp_tvalid && rsp_tready;
   assign wr_ptr_in = wr_ptr_ff + (fire ? QUEUE_PTR_BITS'(scan_out.count) : QUEUE_PTR_BITS'(0));
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
   assign count_in  = count_ff
                      + (fire ? (QUEUE_PTR_BITS+1)'(scan_out.count) : (QUEUE_PTR_BITS+1)'(0))
                      - (QUEUE_PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && scan_out.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= scan_out.tok0;
      end
      if (fire && scan_out.count == 2'd2) begin
         queue_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= scan_out.tok1;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {4'b0000, head.length, head.column, head.row, head.offset, head.kind};
   assign rsp_tlast  = head.last;

endmodule

// ----- hdl/cst_checker.sv -----
// Port-level assertions for the tokenizer top level, with the bind that attaches them.
`include "assert_macros.svh"

module cst_checker import cst_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic is_error;

   assign is_error = (rsp_tdata[3:0] == KIND_ERROR);

   `ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `ASSERT_IMPLY(a_error_ends_run, clock, reset, rsp_tvalid && is_error, rsp_tlast)
   `ASSERT_IMPLY(a_length_nonzero, clock, reset, rsp_tvalid,
                 rsp_tdata[75:60] != 16'd0 && rsp_tdata[43:28] != 16'd0)

endmodule

bind char_stream_tokenizer_unit cst_checker u_cst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
